[rtl/afsr_pkg.sv]
// ----------------------------------------------------------------------------
// afsr_pkg: shared types and constants for the sound control block
// Beat payload structs, action codes, register addresses and length table.
// ----------------------------------------------------------------------------
`default_nettype none
package afsr_pkg;

  localparam int RegFileDepth = 16;
  localparam logic [4:0]  AddrStatus = 5'd21;
  localparam logic [4:0]  AddrFrame  = 5'd23;
  localparam logic [15:0] PeriodMax  = 16'h07FF;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] address;
    logic [7:0] write_data;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [3:0]  pulse_one_volume;
    logic [3:0]  pulse_two_volume;
    logic [3:0]  noise_volume;
    logic [10:0] pulse_one_period;
    logic [10:0] pulse_two_period;
    logic        pulse_one_muted;
    logic        pulse_two_muted;
    logic [6:0]  triangle_linear_count;
    logic [3:0]  length_active_mask;
    logic        frame_interrupt;
    logic [2:0]  sequencer_step;
  } out_beat_t;

  function automatic logic [7:0] length_lookup(input logic [4:0] idx);
    logic [7:0] v;
    unique case (idx)
      5'd0: v = 8'd10;   5'd1: v = 8'd254;  5'd2: v = 8'd20;   5'd3: v = 8'd2;
      5'd4: v = 8'd40;   5'd5: v = 8'd4;    5'd6: v = 8'd80;   5'd7: v = 8'd6;
      5'd8: v = 8'd160;  5'd9: v = 8'd8;    5'd10: v = 8'd60;  5'd11: v = 8'd10;
      5'd12: v = 8'd14;  5'd13: v = 8'd12;  5'd14: v = 8'd26;  5'd15: v = 8'd14;
      5'd16: v = 8'd12;  5'd17: v = 8'd16;  5'd18: v = 8'd24;  5'd19: v = 8'd18;
      5'd20: v = 8'd48;  5'd21: v = 8'd20;  5'd22: v = 8'd96;  5'd23: v = 8'd22;
      5'd24: v = 8'd192; 5'd25: v = 8'd24;  5'd26: v = 8'd72;  5'd27: v = 8'd26;
      5'd28: v = 8'd16;  5'd29: v = 8'd28;  5'd30: v = 8'd32;  default: v = 8'd30;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/afsr_in_stage.sv]
// ----------------------------------------------------------------------------
// afsr_in_stage: input register
// Captures one beat per cycle whenever the core stage can advance or the register is empty.
// ----------------------------------------------------------------------------
`default_nettype none
module afsr_in_stage import afsr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_beat_t in_data,
  input  wire logic     adv,
  output logic          q_valid,
  output in_beat_t      q_data
);
  logic     q_valid_r;
  in_beat_t q_data_r;

  assign in_ready = adv || !q_valid_r;
  assign q_valid  = q_valid_r;
  assign q_data   = q_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (in_ready) begin
      q_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_data_r <= in_data;
    end
  end
endmodule
`default_nettype wire

[rtl/afsr_core.sv]
// ----------------------------------------------------------------------------
// afsr_core: sound control state and result register
// Applies one beat to the full state and registers the result beat.
// ----------------------------------------------------------------------------
`default_nettype none
module afsr_core import afsr_pkg::*; #(
  parameter int REG_FILE_DEPTH = RegFileDepth
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire in_beat_t q_data,
  output logic          adv,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_beat_t     out_data
);
  localparam int AW = $clog2(REG_FILE_DEPTH);

  logic [7:0] regs_r [REG_FILE_DEPTH];
  logic [4:0] en_r;
  logic [7:0] len_r [4];
  logic [2:0] es_r, el_r, ec_r;
  logic [3:0] ediv_r [3], edec_r [3], elev_r [3];
  logic [1:0] sen_r, sneg_r, srel_r, smute_r;
  logic [2:0] ssh_r [2];
  logic [3:0] sper_r [2], sdiv_r [2];
  logic [10:0] per_r [2];
  logic lc_r, lr_r, five_r, inh_r, irq_r;
  logic [6:0] lrv_r, lcnt_r;
  logic [2:0] step_r;
  logic out_valid_r;
  out_beat_t out_r;

  logic [4:0] en_nxt;
  logic [7:0] len_nxt [4];
  logic [2:0] es_nxt, el_nxt, ec_nxt;
  logic [3:0] ediv_nxt [3], edec_nxt [3], elev_nxt [3];
  logic [1:0] sen_nxt, sneg_nxt, srel_nxt, smute_nxt;
  logic [2:0] ssh_nxt [2];
  logic [3:0] sper_nxt [2], sdiv_nxt [2];
  logic [10:0] per_nxt [2];
  logic lc_nxt, lr_nxt, five_nxt, inh_nxt, irq_nxt;
  logic [6:0] lrv_nxt, lcnt_nxt;
  logic [2:0] step_nxt;
  logic [7:0] rd;
  logic qclk, hclk, fire;
  logic [3:0] halt;
  logic [15:0] cur, dlt, tgt;
  logic [1:0] act;
  logic [4:0] a;
  logic [7:0] v;
  out_beat_t res;

  assign adv  = out_ready || !out_valid_r;
  assign fire = q_valid && adv;
  assign act  = q_data.action;
  assign a    = q_data.address;
  assign v    = q_data.write_data;

  always_comb begin
    en_nxt = en_r; es_nxt = es_r; el_nxt = el_r; ec_nxt = ec_r;
    sen_nxt = sen_r; sneg_nxt = sneg_r; srel_nxt = srel_r; smute_nxt = smute_r;
    lc_nxt = lc_r; lr_nxt = lr_r; five_nxt = five_r; inh_nxt = inh_r;
    irq_nxt = irq_r; lrv_nxt = lrv_r; lcnt_nxt = lcnt_r; step_nxt = step_r;
    rd = 8'd0; qclk = 1'b0; hclk = 1'b0;
    cur = '0; dlt = '0; tgt = '0;
    for (int i = 0; i < 4; i++) len_nxt[i] = len_r[i];
    for (int i = 0; i < 3; i++) begin
      ediv_nxt[i] = ediv_r[i]; edec_nxt[i] = edec_r[i]; elev_nxt[i] = elev_r[i];
    end
    for (int i = 0; i < 2; i++) begin
      ssh_nxt[i] = ssh_r[i]; sper_nxt[i] = sper_r[i];
      sdiv_nxt[i] = sdiv_r[i]; per_nxt[i] = per_r[i];
    end
    halt = {regs_r[12][5], regs_r[8][7], regs_r[4][5], regs_r[0][5]};

    // Register write, register read and frame sequencer decoding.
    unique case (action_t'(act))
      ACT_WRITE: begin
        if (a == AddrStatus) begin
          en_nxt = v[4:0];
          for (int p = 0; p < 4; p++) if (!v[p]) len_nxt[p] = 8'd0;
        end else if (a == AddrFrame) begin
          five_nxt = v[7];
          inh_nxt = v[6];
          if (v[6]) irq_nxt = 1'b0;
          step_nxt = 3'd0;
          qclk = v[7];
          hclk = v[7];
        end else if (a < 5'(REG_FILE_DEPTH)) begin
          if (a < 5'd8) begin
            unique case (a[1:0])
              2'd0: begin
                el_nxt[a[2]] = v[5]; ec_nxt[a[2]] = v[4]; elev_nxt[a[2]] = v[3:0];
              end
              2'd1: begin
                sen_nxt[a[2]] = v[7]; sper_nxt[a[2]] = {1'b0, v[6:4]} + 4'd1;
                sneg_nxt[a[2]] = v[3]; ssh_nxt[a[2]] = v[2:0];
                srel_nxt[a[2]] = 1'b1;
              end
              2'd2: per_nxt[a[2]] = {per_r[a[2]][10:8], v};
              default: begin
                if (en_r[a[2]]) len_nxt[a[2]] = length_lookup(v[7:3]);
                per_nxt[a[2]] = {v[2:0], per_r[a[2]][7:0]};
                es_nxt[a[2]] = 1'b1;
              end
            endcase
          end else if (a == 5'd8) begin
            lc_nxt = v[7]; lrv_nxt = v[6:0];
          end else if (a == 5'd11) begin
            if (en_r[2]) len_nxt[2] = length_lookup(v[7:3]);
            lr_nxt = 1'b1;
          end else if (a == 5'd12) begin
            el_nxt[2] = v[5]; ec_nxt[2] = v[4]; elev_nxt[2] = v[3:0];
          end else if (a == 5'd15) begin
            if (en_r[3]) len_nxt[3] = length_lookup(v[7:3]);
            es_nxt[2] = 1'b1;
          end
        end
      end
      ACT_READ: begin
        if (a == AddrStatus) begin
          rd = {1'b0, irq_r, 1'b0, en_r};
          irq_nxt = 1'b0;
        end else if (a < 5'(REG_FILE_DEPTH)) begin
          rd = regs_r[a[AW-1:0]];
        end
      end
      ACT_TICK: begin
        if (!five_r) begin
          qclk = 1'b1;
          hclk = (step_r == 3'd1) || (step_r == 3'd3);
          if (step_r == 3'd3 && !inh_r) irq_nxt = 1'b1;
          step_nxt = (step_r >= 3'd3) ? 3'd0 : step_r + 3'd1;
        end else begin
          qclk = (step_r != 3'd3);
          hclk = (step_r == 3'd1) || (step_r == 3'd4);
          step_nxt = (step_r >= 3'd4) ? 3'd0 : step_r + 3'd1;
        end
      end
      default: ;
    endcase

    // Quarter frame: envelopes and linear counter.
    if (qclk) begin
      for (int i = 0; i < 3; i++) begin
        if (es_r[i]) begin
          es_nxt[i] = 1'b0; edec_nxt[i] = 4'd15; ediv_nxt[i] = elev_r[i];
        end else if (ediv_r[i] != 4'd0) begin
          ediv_nxt[i] = ediv_r[i] - 4'd1;
        end else begin
          ediv_nxt[i] = elev_r[i];
          if (edec_r[i] != 4'd0) edec_nxt[i] = edec_r[i] - 4'd1;
          else if (el_r[i]) edec_nxt[i] = 4'd15;
        end
      end
      if (lr_r) lcnt_nxt = lrv_r;
      else if (lcnt_r != 7'd0) lcnt_nxt = lcnt_r - 7'd1;
      if (!lc_r) lr_nxt = 1'b0;
    end

    // Half frame: length counters and sweeps.
    if (hclk) begin
      for (int i = 0; i < 4; i++)
        if (!halt[i] && len_r[i] != 8'd0) len_nxt[i] = len_r[i] - 8'd1;
      for (int c = 0; c < 2; c++) begin
        if (srel_r[c]) begin
          sdiv_nxt[c] = sper_r[c]; srel_nxt[c] = 1'b0;
        end else if (sdiv_r[c] != 4'd0) begin
          sdiv_nxt[c] = sdiv_r[c] - 4'd1;
        end else begin
          sdiv_nxt[c] = sper_r[c];
          if (sen_r[c] && ssh_r[c] != 3'd0) begin
            cur = {5'd0, per_r[c]};
            dlt = cur >> ssh_r[c];
            if (!sneg_r[c]) tgt = cur + dlt;
            else if (c == 0) tgt = cur + ~dlt;
            else tgt = cur - dlt;
            if (tgt < 16'd8 || tgt > PeriodMax) smute_nxt[c] = 1'b1;
            else begin
              per_nxt[c] = tgt[10:0]; smute_nxt[c] = 1'b0;
            end
          end
        end
      end
    end

    res.read_data = rd;
    res.pulse_one_volume = ec_nxt[0] ? elev_nxt[0] : edec_nxt[0];
    res.pulse_two_volume = ec_nxt[1] ? elev_nxt[1] : edec_nxt[1];
    res.noise_volume = ec_nxt[2] ? elev_nxt[2] : edec_nxt[2];
    res.pulse_one_period = per_nxt[0];
    res.pulse_two_period = per_nxt[1];
    res.pulse_one_muted = smute_nxt[0];
    res.pulse_two_muted = smute_nxt[1];
    res.triangle_linear_count = lcnt_nxt;
    for (int i = 0; i < 4; i++) res.length_active_mask[i] = (len_nxt[i] != 8'd0);
    res.frame_interrupt = irq_nxt;
    res.sequencer_step = step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_FILE_DEPTH; i++) regs_r[i] <= 8'd0;
      en_r <= '0; es_r <= '0; el_r <= '0; ec_r <= '0;
      sen_r <= '0; sneg_r <= '0; srel_r <= '0; smute_r <= '0;
      lc_r <= 1'b0; lr_r <= 1'b0; five_r <= 1'b0; inh_r <= 1'b0; irq_r <= 1'b0;
      lrv_r <= '0; lcnt_r <= '0; step_r <= '0;
      for (int i = 0; i < 4; i++) len_r[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        ediv_r[i] <= '0; edec_r[i] <= '0; elev_r[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        ssh_r[i] <= '0; sper_r[i] <= '0; sdiv_r[i] <= '0; per_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (adv) out_valid_r <= q_valid;
      if (fire) begin
        if (act == ACT_WRITE && a < 5'(REG_FILE_DEPTH)) regs_r[a[AW-1:0]] <= v;
        en_r <= en_nxt; es_r <= es_nxt; el_r <= el_nxt; ec_r <= ec_nxt;
        sen_r <= sen_nxt; sneg_r <= sneg_nxt; srel_r <= srel_nxt; smute_r <= smute_nxt;
        lc_r <= lc_nxt; lr_r <= lr_nxt; five_r <= five_nxt; inh_r <= inh_nxt;
        irq_r <= irq_nxt; lrv_r <= lrv_nxt; lcnt_r <= lcnt_nxt; step_r <= step_nxt;
        for (int i = 0; i < 4; i++) len_r[i] <= len_nxt[i];
        for (int i = 0; i < 3; i++) begin
          ediv_r[i] <= ediv_nxt[i]; edec_r[i] <= edec_nxt[i]; elev_r[i] <= elev_nxt[i];
        end
        for (int i = 0; i < 2; i++) begin
          ssh_r[i] <= ssh_nxt[i]; sper_r[i] <= sper_nxt[i];
          sdiv_r[i] <= sdiv_nxt[i]; per_r[i] <= per_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= 3'd4) else $error("sequencer step out of range");
  a_four_step: assert property (@(posedge clk) disable iff (!rst_n)
    !five_r |-> step_r <= 3'd3) else $error("four-step index out of range");
  a_status_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && act == ACT_READ && a == AddrStatus |=> !irq_r)
    else $error("status read did not clear interrupt");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(out_r)) else $error("result changed under stall");
endmodule
`default_nettype wire

[rtl/apu_frame_sequencer_registers.sv]
// ----------------------------------------------------------------------------
// apu_frame_sequencer_registers: control section of a sound unit
// Register file, length counters, envelopes, sweeps, linear counter and
// frame sequencer, driven by bus writes, bus reads and quarter-frame ticks.
// ----------------------------------------------------------------------------
// Each input beat is a register write, a register read, one quarter-frame
// tick of the sequencer or a no-op. Every input beat produces exactly one
// result beat that carries the read byte and a snapshot of the channel
// state after it. A beat sits in the input register after it is accepted,
// the state update and result are computed from there in a single pass,
// and the result register takes them once it is free or being read. One
// beat is taken every cycle while the result side keeps up. When the
// receiver stalls the result beat holds steady, the input register takes
// a beat only while it is empty, and in_ready stays low until the result
// is taken. Synchronous reset clears the register file and all counter,
// sweep and sequencer state and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none
module apu_frame_sequencer_registers import afsr_pkg::*; #(
  parameter int REG_FILE_DEPTH = RegFileDepth
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_beat_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_beat_t     out_data
);
  logic     adv;
  logic     q_valid;
  in_beat_t q_data;

  // Input register: decouples the bus from the state update.
  afsr_in_stage u_in (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .adv, .q_valid, .q_data
  );

  // State update and result register.
  afsr_core #(.REG_FILE_DEPTH(REG_FILE_DEPTH)) u_core (
    .clk, .rst_n, .q_valid, .q_data, .adv,
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire
